[rtl/lbsl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light band controller package
// Shared item types, controller state, constants and the band window table.
// ----------------------------------------------------------------------------
package lbsl_pkg;

    localparam int unsigned LUX_W    = 16;
    localparam int unsigned LEVEL_W  = 10;
    localparam int unsigned BAND_W   = 3;
    localparam int unsigned WINDOW_W = 15;
    localparam int unsigned ANGLE_W  = 8;
    localparam int unsigned DUTY_W   = 8;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [BAND_W-1:0]  BAND_MAX        = 3'd6;
    localparam logic [ANGLE_W-1:0] SHADE_MAX       = 8'd180;
    localparam logic [ANGLE_W-1:0] SHADE_HOME      = 8'd90;
    localparam logic [DUTY_W-1:0]  LAMP_MAX        = 8'd255;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 10'd30;

    // Packed in tdata order, last field in the lowest bits.
    typedef struct packed {
        logic               start_press;
        logic               down_press;
        logic               up_press;
        logic               menu_press;
        logic [LEVEL_W-1:0] photo_level;
        logic [LUX_W-1:0]   lux;
    } in_item_t;

    typedef struct packed {
        logic [BAND_W-1:0]  band_now;
        logic               regulating;
        logic               menu_open;
        logic               lamp_write;
        logic [DUTY_W-1:0]  lamp_duty;
        logic               shade_write;
        logic [ANGLE_W-1:0] shade_angle;
    } out_item_t;

    typedef struct packed {
        logic                menu_state;
        logic                run_flag;
        logic [BAND_W-1:0]   band_index;
        logic [WINDOW_W-1:0] window_low;
        logic [WINDOW_W-1:0] window_high;
        logic [ANGLE_W-1:0]  shade_position;
        logic [DUTY_W-1:0]   lamp_level;
        logic [ANGLE_W-1:0]  shade_cmd;
        logic [DUTY_W-1:0]   lamp_cmd;
    } ctrl_state_t;

    function automatic logic [WINDOW_W-1:0] band_low(input logic [BAND_W-1:0] idx);
        logic [WINDOW_W-1:0] v;
        case (idx)
            3'd1:    v = 15'd100;
            3'd2:    v = 15'd500;
            3'd3:    v = 15'd1000;
            3'd4:    v = 15'd1500;
            3'd5:    v = 15'd10000;
            3'd6:    v = 15'd20000;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [WINDOW_W-1:0] band_high(input logic [BAND_W-1:0] idx);
        logic [WINDOW_W-1:0] v;
        case (idx)
            3'd1:    v = 15'd500;
            3'd2:    v = 15'd1000;
            3'd3:    v = 15'd1500;
            3'd4:    v = 15'd2000;
            3'd5:    v = 15'd20000;
            3'd6:    v = 15'd30000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/lbsl_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light band controller input stage
// Registers one incoming transaction and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
module lbsl_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  lbsl_pkg::in_item_t in_item,
    output logic               item_valid,
    input  logic               item_take,
    output lbsl_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    lbsl_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/lbsl_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light band controller step logic
// Menu handling, band selection and one regulation step for one control tick.
// ----------------------------------------------------------------------------
module lbsl_step (
    input  lbsl_pkg::in_item_t                  item,
    input  lbsl_pkg::ctrl_state_t               cur,
    input  logic [lbsl_pkg::LEVEL_W-1:0]        dark_threshold,
    output lbsl_pkg::ctrl_state_t               nxt,
    output lbsl_pkg::out_item_t                 result
);

    logic                          lux_below;
    logic                          lux_above;
    logic [lbsl_pkg::BAND_W:0]     idx_up;
    logic [lbsl_pkg::BAND_W:0]     idx_dn;
    logic [lbsl_pkg::BAND_W-1:0]   idx_new;
    logic [lbsl_pkg::WINDOW_W-1:0] win_low;
    logic [lbsl_pkg::WINDOW_W-1:0] win_high;
    logic [lbsl_pkg::ANGLE_W-1:0]  shade_dn;
    logic [lbsl_pkg::ANGLE_W-1:0]  shade_stepped;
    logic [lbsl_pkg::DUTY_W-1:0]   lamp_up;
    logic [lbsl_pkg::DUTY_W-1:0]   lamp_stepped;
    logic                          shade_w;
    logic                          lamp_w;

    // Band index moves by the net of the two presses and is clamped to 0..6.
    always_comb begin
        idx_up = {1'b0, cur.band_index} + {{lbsl_pkg::BAND_W{1'b0}}, item.up_press};
        if (item.down_press && idx_up != '0) begin
            idx_dn = idx_up - 1'b1;
        end else begin
            idx_dn = idx_up;
        end
        if (idx_dn > {1'b0, lbsl_pkg::BAND_MAX}) begin
            idx_new = lbsl_pkg::BAND_MAX;
        end else begin
            idx_new = idx_dn[lbsl_pkg::BAND_W-1:0];
        end
    end

    // Band zero keeps whatever window was loaded before.
    assign win_low  = (idx_new != '0) ? lbsl_pkg::band_low(idx_new)  : cur.window_low;
    assign win_high = (idx_new != '0) ? lbsl_pkg::band_high(idx_new) : cur.window_high;

    assign lux_below = item.lux < {1'b0, win_low};
    assign lux_above = item.lux > {1'b0, win_high};

    // Both steps are applied in turn: the shade steps down first, the lamp up first.
    assign shade_dn      = (lux_below && cur.shade_position != '0)
                           ? cur.shade_position - 1'b1 : cur.shade_position;
    assign shade_stepped = (lux_above && shade_dn < lbsl_pkg::SHADE_MAX)
                           ? shade_dn + 1'b1 : shade_dn;
    assign lamp_up       = (lux_below && cur.lamp_level != lbsl_pkg::LAMP_MAX)
                           ? cur.lamp_level + 1'b1 : cur.lamp_level;
    assign lamp_stepped  = (lux_above && lamp_up != '0) ? lamp_up - 1'b1 : lamp_up;

    always_comb begin
        nxt     = cur;
        shade_w = 1'b0;
        lamp_w  = 1'b0;
        if (item.menu_press && cur.menu_state) begin
            // A second menu press aborts: lamp off, menu and run mode closed.
            nxt.lamp_cmd   = '0;
            lamp_w         = 1'b1;
            nxt.menu_state = 1'b0;
            nxt.run_flag   = 1'b0;
        end else if (item.menu_press || cur.menu_state) begin
            nxt.menu_state  = 1'b1;
            nxt.band_index  = idx_new;
            nxt.window_low  = win_low;
            nxt.window_high = win_high;
            nxt.run_flag    = cur.run_flag || item.start_press;
            if (nxt.run_flag) begin
                if (item.photo_level > dark_threshold) begin
                    nxt.lamp_cmd       = '0;
                    lamp_w             = 1'b1;
                    nxt.shade_position = shade_stepped;
                    nxt.shade_cmd      = shade_stepped;
                    shade_w            = 1'b1;
                end else if (item.photo_level < dark_threshold) begin
                    nxt.shade_cmd  = lbsl_pkg::SHADE_HOME;
                    shade_w        = 1'b1;
                    nxt.lamp_level = lamp_stepped;
                    nxt.lamp_cmd   = lamp_stepped;
                    lamp_w         = 1'b1;
                end
            end
        end
    end

    always_comb begin
        result.shade_angle = nxt.shade_cmd;
        result.shade_write = shade_w;
        result.lamp_duty   = nxt.lamp_cmd;
        result.lamp_write  = lamp_w;
        result.menu_open   = nxt.menu_state;
        result.regulating  = nxt.run_flag;
        result.band_now    = nxt.band_index;
    end

endmodule

[rtl/light_band_shade_and_lamp_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light band shade and lamp controller
// Menu-driven band selection with day shade and night lamp regulation.
// ----------------------------------------------------------------------------
// One input transaction on the s_ channel is one control tick: a lux reading,
// a photocell level and four button presses. Each tick gives exactly one
// result transaction on the m_ channel with the shade and lamp commands, their
// write strobes, the menu and run flags and the selected band.
// A tick is held in the input register; the step logic then updates the
// controller state and loads the result register that drives m_tdata. One
// tick is taken every cycle while the receiver keeps up; the limit is the
// single result register. When the receiver stalls, the result holds in the
// output register while one more tick waits in the input register; s_tready
// drops only when both are full. Reset empties both registers, closes the
// menu, stops regulation, selects band zero, parks the shade at 90 with the
// lamp off, and loads the dark threshold with 30. cfg_wr_en writes a new
// threshold; the user must do so only while idle, unenforced by the block.
// ----------------------------------------------------------------------------
module light_band_shade_and_lamp_controller_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lbsl_pkg::LEVEL_W-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // lux[15:0], photo_level[25:16], menu_press[26], up_press[27],
    // down_press[28], start_press[29], zero[31:30]
    input  logic [lbsl_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // shade_angle[7:0], shade_write[8], lamp_duty[16:9], lamp_write[17],
    // menu_open[18], regulating[19], band_now[22:20], zero[23]
    output logic [lbsl_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned ITEM_W = $bits(lbsl_pkg::in_item_t);
    localparam int unsigned RES_W  = $bits(lbsl_pkg::out_item_t);

    lbsl_pkg::in_item_t     s_item;
    lbsl_pkg::in_item_t     item;
    logic                   item_valid;
    logic                   item_take;
    lbsl_pkg::ctrl_state_t  state_reg;
    lbsl_pkg::ctrl_state_t  state_next;
    lbsl_pkg::out_item_t    result;
    lbsl_pkg::out_item_t    result_reg;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [lbsl_pkg::LEVEL_W-1:0] threshold_reg;

    assign s_item = lbsl_pkg::in_item_t'(s_tdata[ITEM_W-1:0]);

    lbsl_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    lbsl_step u_step (
        .item           (item),
        .cur            (state_reg),
        .dark_threshold (threshold_reg),
        .nxt            (state_next),
        .result         (result)
    );

    // The state advances only when the tick moves into the result register.
    assign item_take    = item_valid && (!m_valid_reg || m_tready);
    assign m_valid_next = item_take || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg              <= 1'b0;
            threshold_reg            <= lbsl_pkg::THRESHOLD_RESET;
            state_reg.menu_state     <= 1'b0;
            state_reg.run_flag       <= 1'b0;
            state_reg.band_index     <= '0;
            state_reg.window_low     <= '0;
            state_reg.window_high    <= '0;
            state_reg.shade_position <= lbsl_pkg::SHADE_HOME;
            state_reg.lamp_level     <= '0;
            state_reg.shade_cmd      <= lbsl_pkg::SHADE_HOME;
            state_reg.lamp_cmd       <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                threshold_reg <= cfg_wr_data;
            end
            if (item_take) begin
                state_reg <= state_next;
            end
        end
        if (item_take) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lbsl_pkg::M_TDATA_W - RES_W){1'b0}}, result_reg};

endmodule

[rtl/lbsl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light band controller port checker
// Watches the top-level ports for result ordering and value limits.
// ----------------------------------------------------------------------------
module lbsl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lbsl_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Nothing is offered in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Run mode only exists with the menu open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> m_tdata[18])
        else $error("regulating with menu closed");

    // Band index and shade angle stay within their ranges.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[22:20] <= lbsl_pkg::BAND_MAX
                     && m_tdata[7:0] <= lbsl_pkg::SHADE_MAX)
        else $error("band or angle out of range");

    // An accepted tick always yields a result when the receiver does not stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready |-> m_tvalid || $past(m_tvalid))
        else $error("accepted tick produced no result");

endmodule

bind light_band_shade_and_lamp_controller_top lbsl_checker u_lbsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
